### rtl/core/ifd_pkg.sv
package ifd_pkg;

  localparam int unsigned IFD_W       = 64;
  localparam int unsigned IFD_STEPS   = IFD_W;
  localparam int unsigned IFD_LATENCY = IFD_STEPS + 3;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_DIV_ZERO = 2'd1;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]       op;
    logic [1:0]       fault;
    logic             neg_num;
    logic             neg_den;
    logic [IFD_W-1:0] val;
    logic [IFD_W-1:0] num;
    logic [IFD_W-1:0] den;
    logic [IFD_W-1:0] quo;
    logic [IFD_W-1:0] rem;
  } ifd_beat_t;

endpackage

### rtl/core/ifd_div_stage.sv
module ifd_div_stage
  import ifd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  ifd_beat_t in_beat,
  output logic      out_valid_r,
  output ifd_beat_t out_beat_r
);

  logic [IFD_W:0]   rem_sh;
  logic [IFD_W:0]   diff;
  logic             take;
  ifd_beat_t        beat_nxt;

  always_comb begin
    rem_sh   = {in_beat.rem, in_beat.num[IFD_W-1]};
    diff     = rem_sh - {1'b0, in_beat.den};
    take     = !diff[IFD_W];
    beat_nxt = in_beat;
    beat_nxt.num = {in_beat.num[IFD_W-2:0], 1'b0};
    beat_nxt.quo = {in_beat.quo[IFD_W-2:0], take};
    beat_nxt.rem = take ? diff[IFD_W-1:0] : rem_sh[IFD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= beat_nxt;
  end

endmodule

### rtl/core/int64_alu_floor_divmod.sv
// channel  | ports                                        | handshake
// input    | in_req_type, in_lhs_value, in_rhs_value      | start && !busy
// result   | out_result_value, out_fault_code             | out_valid, one cycle
//
// The pipeline has one operand stage, 64 divide stages (one quotient bit
// each) and two sign-fixup stages. One beat enters every cycle; busy stays low.
// Add, subtract and multiply ride the same stages so results leave in order.
// Synchronous reset clears the valid bits only; beats in flight are dropped.
// The receiver cannot stall, so nothing holds the pipeline.
module int64_alu_floor_divmod
  import ifd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_req_type,
  input  logic signed [IFD_W-1:0] in_lhs_value,
  input  logic signed [IFD_W-1:0] in_rhs_value,
  output logic                    out_valid,
  output logic signed [IFD_W-1:0] out_result_value,
  output logic [1:0]              out_fault_code
);

  localparam int unsigned HW = IFD_W / 2;

  ifd_beat_t        s0_nxt, s0_r;
  logic             s0_valid_r;
  logic [IFD_W-1:0] pp_ll_r, pp_ll_nxt;
  logic [HW-1:0]    pp_lh_r, pp_hl_r, pp_lh_nxt, pp_hl_nxt;
  logic             is_div;

  ifd_beat_t        st_beat [IFD_STEPS+1];
  logic             st_valid [IFD_STEPS+1];

  ifd_beat_t        f1_nxt, f1_r;
  logic             f1_valid_r;
  logic [IFD_W-1:0] f2_value_nxt, f2_value_r;
  logic [1:0]       f2_fault_r;
  logic             f2_valid_r;
  logic [IFD_W-1:0] rem_signed;
  logic             opp;
  logic             rem_nz;

  assign busy = 1'b0;

  always_comb begin
    is_div = (in_req_type == OP_DIV) || (in_req_type == OP_MOD);
    s0_nxt = '0;
    s0_nxt.op      = in_req_type;
    s0_nxt.neg_num = in_lhs_value[IFD_W-1];
    s0_nxt.neg_den = in_rhs_value[IFD_W-1];
    s0_nxt.num     = in_lhs_value[IFD_W-1] ? -in_lhs_value : in_lhs_value;
    s0_nxt.den     = in_rhs_value[IFD_W-1] ? -in_rhs_value : in_rhs_value;
    priority if (is_div && in_rhs_value == '0) begin
      s0_nxt.fault = FAULT_DIV_ZERO;
    end else if (is_div && in_lhs_value == {1'b1, {(IFD_W-1){1'b0}}}
                 && in_rhs_value == {IFD_W{1'b1}}) begin
      s0_nxt.fault = FAULT_OVERFLOW;
    end else begin
      s0_nxt.fault = FAULT_NONE;
    end
    unique case (in_req_type)
      OP_ADD:  s0_nxt.val = in_lhs_value + in_rhs_value;
      OP_SUB:  s0_nxt.val = in_lhs_value - in_rhs_value;
      default: s0_nxt.val = '0;
    endcase
    pp_ll_nxt = in_lhs_value[HW-1:0] * in_rhs_value[HW-1:0];
    pp_lh_nxt = HW'(in_lhs_value[HW-1:0] * in_rhs_value[IFD_W-1:HW]);
    pp_hl_nxt = HW'(in_lhs_value[IFD_W-1:HW] * in_rhs_value[HW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_r    <= s0_nxt;
    pp_ll_r <= pp_ll_nxt;
    pp_lh_r <= pp_lh_nxt;
    pp_hl_r <= pp_hl_nxt;
  end

  always_comb begin
    st_valid[0] = s0_valid_r;
    st_beat[0]  = s0_r;
    if (s0_r.op == OP_MUL) begin
      st_beat[0].val = pp_ll_r + {pp_lh_r + pp_hl_r, {HW{1'b0}}};
    end
  end

  for (genvar k = 0; k < IFD_STEPS; k++) begin : g_step
    ifd_div_stage u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (st_valid[k]),
      .in_beat    (st_beat[k]),
      .out_valid_r(st_valid[k+1]),
      .out_beat_r (st_beat[k+1])
    );
  end

  always_comb begin
    f1_nxt = st_beat[IFD_STEPS];
    opp    = f1_nxt.neg_num ^ f1_nxt.neg_den;
    rem_nz = f1_nxt.rem != '0;
    if (opp) begin
      f1_nxt.quo = rem_nz ? ~st_beat[IFD_STEPS].quo : -st_beat[IFD_STEPS].quo;
    end
    if (opp && rem_nz) begin
      f1_nxt.rem = st_beat[IFD_STEPS].den - st_beat[IFD_STEPS].rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= st_valid[IFD_STEPS];
      f2_valid_r <= f1_valid_r;
    end
  end

  always_comb begin
    rem_signed = f1_r.neg_den ? -f1_r.rem : f1_r.rem;
    if (f1_r.fault != FAULT_NONE) begin
      f2_value_nxt = '0;
    end else begin
      unique case (f1_r.op)
        OP_ADD, OP_SUB, OP_MUL: f2_value_nxt = f1_r.val;
        OP_DIV:                 f2_value_nxt = f1_r.quo;
        OP_MOD:                 f2_value_nxt = rem_signed;
        default:                f2_value_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    f1_r       <= f1_nxt;
    f2_value_r <= f2_value_nxt;
    f2_fault_r <= f1_r.fault;
  end

  assign out_valid        = f2_valid_r;
  assign out_result_value = f2_value_r;
  assign out_fault_code   = f2_fault_r;

endmodule

### rtl/core/ifd_checker.sv
module ifd_checker
  import ifd_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [2:0]              in_req_type,
  input logic signed [IFD_W-1:0] in_rhs_value,
  input logic                    out_valid,
  input logic signed [IFD_W-1:0] out_result_value,
  input logic [1:0]              out_fault_code
);

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##IFD_LATENCY out_valid)
    else $error("accepted beat did not come out");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, IFD_LATENCY))
    else $error("result without a beat");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault_code != FAULT_NONE) |-> out_result_value == '0)
    else $error("faulted result not zero");

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_rhs_value == '0
     && (in_req_type == OP_DIV || in_req_type == OP_MOD))
    |-> ##IFD_LATENCY out_fault_code == FAULT_DIV_ZERO)
    else $error("zero divisor not flagged");

endmodule

bind int64_alu_floor_divmod ifd_checker u_ifd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .in_rhs_value    (in_rhs_value),
  .out_valid       (out_valid),
  .out_result_value(out_result_value),
  .out_fault_code  (out_fault_code)
);

### bench/int64_alu_floor_divmod_test.sv
module int64_alu_floor_divmod_test;
  import ifd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM   = 1500;
  localparam int unsigned STALL_MAX  = 2000;
  localparam logic [63:0] MIN_V      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_V      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG1       = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  fault;
  } alu_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic        fixed;
    alu_res_t    res;
  } vec_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [2:0]              in_req_type;
  logic signed [IFD_W-1:0] in_lhs_value;
  logic signed [IFD_W-1:0] in_rhs_value;
  logic                    out_valid;
  logic signed [IFD_W-1:0] out_result_value;
  logic [1:0]              out_fault_code;

  alu_res_t    pending_q[$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_beats;
  int unsigned idle_cycles;
  int unsigned n_div_faults;
  vec_t        vectors[$];

  int64_alu_floor_divmod u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_lhs_value     (in_lhs_value),
    .in_rhs_value     (in_rhs_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_fault_code   (out_fault_code)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic alu_res_t alu_predict(logic [2:0] op, logic [63:0] lhs,
                                           logic [63:0] rhs);
    alu_res_t         r;
    logic signed [63:0] n;
    logic signed [63:0] d;
    logic signed [63:0] q;
    logic signed [63:0] m;
    r = '{value: '0, fault: FAULT_NONE};
    n = lhs;
    d = rhs;
    case (op)
      OP_ADD: r.value = lhs + rhs;
      OP_SUB: r.value = lhs - rhs;
      OP_MUL: r.value = lhs * rhs;
      OP_DIV, OP_MOD: begin
        if (rhs == '0) begin
          r.fault = FAULT_DIV_ZERO;
        end else if (lhs == MIN_V && rhs == NEG1) begin
          r.fault = FAULT_OVERFLOW;
        end else begin
          q = n / d;
          m = n % d;
          if (m != 0 && ((n < 0) != (d < 0))) begin
            q = q - 1;
            m = m + d;
          end
          r.value = (op == OP_DIV) ? q : m;
        end
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  task automatic report(string what, alu_res_t got, alu_res_t exp_r);
    n_errors++;
    $display("MISMATCH %s: got value %h fault %0d, want value %h fault %0d",
             what, got.value, got.fault, exp_r.value, exp_r.fault);
  endtask

  always @(posedge clk) begin
    alu_res_t got;
    alu_res_t exp_r;
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid) begin
        got = '{value: out_result_value, fault: out_fault_code};
        n_results++;
        if (pending_q.size() == 0) begin
          exp_r = '{value: '0, fault: FAULT_NONE};
          report("unexpected beat, nothing pending", got, exp_r);
        end else begin
          exp_r = pending_q.pop_front();
          if (got.value !== exp_r.value) report("value", got, exp_r);
          else if (got.fault !== exp_r.fault) report("fault", got, exp_r);
        end
      end
      if (idle_cycles >= STALL_MAX) begin
        $display("timeout: no beat for %0d cycles", STALL_MAX);
        $display("int64_alu_floor_divmod_test failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = MIN_V;
      1: v = MAX_V;
      2: v = NEG1;
      3: v = '0;
      4: v = 64'(signed'(32'($urandom_range(0, 20)) - 32'd10));
      5: v = 64'(signed'($urandom));
      6: v = v >> $urandom_range(1, 63);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] rand_op();
    if ($urandom_range(0, 19) == 0) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(0, 4));
  endfunction

  task automatic add_vec(logic [2:0] op, logic [63:0] lhs, logic [63:0] rhs,
                         logic fixed, logic [63:0] value, logic [1:0] fault);
    vec_t v;
    v.op = op;
    v.lhs = lhs;
    v.rhs = rhs;
    v.fixed = fixed;
    v.res = '{value: value, fault: fault};
    vectors.push_back(v);
  endtask

  task automatic send(logic [2:0] op, logic [63:0] lhs, logic [63:0] rhs,
                      alu_res_t exp_r, bit may_idle);
    if (may_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start        <= 1'b1;
    in_req_type  <= op;
    in_lhs_value <= lhs;
    in_rhs_value <= rhs;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(exp_r);
    n_beats++;
    if (op inside {OP_DIV, OP_MOD} && (rhs == '0 || (lhs == MIN_V && rhs == NEG1)))
      n_div_faults++;
  endtask

  initial begin
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    alu_res_t    r;
    n_errors = 0;
    n_results = 0;
    n_beats = 0;
    idle_cycles = 0;
    n_div_faults = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = OP_ADD;
    in_lhs_value = '0;
    in_rhs_value = '0;

    add_vec(OP_ADD, MAX_V, 64'd1, 1'b1, MIN_V, FAULT_NONE);
    add_vec(OP_SUB, MIN_V, 64'd1, 1'b1, MAX_V, FAULT_NONE);
    add_vec(OP_MUL, MIN_V, NEG1, 1'b1, MIN_V, FAULT_NONE);
    add_vec(OP_MUL, MAX_V, MAX_V, 1'b0, '0, FAULT_NONE);
    add_vec(OP_DIV, 64'd5, '0, 1'b1, '0, FAULT_DIV_ZERO);
    add_vec(OP_MOD, MIN_V, '0, 1'b1, '0, FAULT_DIV_ZERO);
    add_vec(OP_DIV, MIN_V, NEG1, 1'b1, '0, FAULT_OVERFLOW);
    add_vec(OP_MOD, MIN_V, NEG1, 1'b1, '0, FAULT_OVERFLOW);
    add_vec(OP_DIV, 64'd7, 64'd2, 1'b1, 64'd3, FAULT_NONE);
    add_vec(OP_DIV, -64'sd7, 64'd2, 1'b1, -64'sd4, FAULT_NONE);
    add_vec(OP_MOD, -64'sd7, 64'd2, 1'b1, 64'd1, FAULT_NONE);
    add_vec(OP_MOD, 64'd7, -64'sd2, 1'b1, NEG1, FAULT_NONE);
    add_vec(OP_DIV, -64'sd8, -64'sd2, 1'b1, 64'd4, FAULT_NONE);
    add_vec(OP_DIV, MIN_V, 64'd1, 1'b1, MIN_V, FAULT_NONE);
    add_vec(OP_MOD, MIN_V, MAX_V, 1'b0, '0, FAULT_NONE);
    add_vec(OP_DIV, MAX_V, MIN_V, 1'b0, '0, FAULT_NONE);
    add_vec(OP_DIV, NEG1, MAX_V, 1'b0, '0, FAULT_NONE);
    add_vec(3'd5, MAX_V, NEG1, 1'b1, '0, FAULT_NONE);
    add_vec(3'd6, MIN_V, MIN_V, 1'b1, '0, FAULT_NONE);
    add_vec(3'd7, NEG1, NEG1, 1'b1, '0, FAULT_NONE);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      r = vectors[i].fixed ? vectors[i].res
                           : alu_predict(vectors[i].op, vectors[i].lhs, vectors[i].rhs);
      send(vectors[i].op, vectors[i].lhs, vectors[i].rhs, r, 1'b1);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      op = rand_op();
      a = rand_operand();
      b = rand_operand();
      send(op, a, b, alu_predict(op, a, b), i < N_RANDOM - 200);
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (IFD_LATENCY + 10) @(posedge clk);

    $display("covered %0d beats (%0d divide faults), %0d results checked",
             n_beats, n_div_faults, n_results);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("int64_alu_floor_divmod_test passed");
    end else begin
      $display("int64_alu_floor_divmod_test failed");
    end
    $finish;
  end

endmodule
